[src/temporal_frame_averager_defines.svh]
// Assertion macros for the temporal frame averager.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef TEMPORAL_FRAME_AVERAGER_DEFINES_SVH
`define TEMPORAL_FRAME_AVERAGER_DEFINES_SVH

`ifndef SYNTH
`define TFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tfa check failed");
`define TFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tfa check failed");
`else
`define TFA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TFA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[src/tfa_pkg.sv]
// Shared types, codes and the divider step function for the frame averager.
// No dependencies.
`default_nettype none

package tfa_pkg;

    localparam int SUM_W      = 23;
    localparam int SAMPLE_W   = 16;
    localparam int FRAMES_W   = 7;
    localparam int FMT_W      = 2;
    localparam int ELEMS_W    = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = ELEMS_W;
    localparam int CHUNK_W    = 8;
    localparam int DIV_STAGES = 3;
    localparam int DVD_W      = CHUNK_W * DIV_STAGES;

    localparam logic [FMT_W-1:0] FMT_8BIT   = 2'd0;
    localparam logic [FMT_W-1:0] FMT_LE16   = 2'd1;
    localparam logic [FMT_W-1:0] FMT_BE16   = 2'd2;
    localparam logic [FMT_W-1:0] FMT_UNUSED = 2'd3;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAMES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENTS = 2'd2;

    localparam logic [FRAMES_W-1:0] FRAMES_RESET   = 7'd10;
    localparam logic [FMT_W-1:0]    FORMAT_RESET   = FMT_8BIT;
    localparam logic [ELEMS_W-1:0]  ELEMENTS_RESET = 21'd1048576;

    typedef struct packed {
        logic [FRAMES_W-1:0] divisor;
        logic [FMT_W-1:0]    fmt;
        logic                last;
    } div_side_t;

    // eight restoring steps: returns {remainder, quotient bits}
    function automatic logic [FRAMES_W+CHUNK_W-1:0] div_chunk(
        input logic [FRAMES_W-1:0] rem_in,
        input logic [CHUNK_W-1:0]  bits,
        input logic [FRAMES_W-1:0] divisor
    );
        logic [FRAMES_W-1:0] rem;
        logic [FRAMES_W:0]   trial;
        logic [CHUNK_W-1:0]  quo;
        rem = rem_in;
        quo = '0;
        for (int i = CHUNK_W - 1; i >= 0; i--)
        begin
            trial = {rem, bits[i]};
            if (trial >= {1'b0, divisor})
            begin
                rem    = FRAMES_W'(trial - {1'b0, divisor});
                quo[i] = 1'b1;
            end
            else
            begin
                rem = trial[FRAMES_W-1:0];
            end
        end
        return {rem, quo};
    endfunction

    function automatic logic [SAMPLE_W-1:0] swap_bytes(input logic [SAMPLE_W-1:0] v);
        return {v[7:0], v[15:8]};
    endfunction

endpackage

`default_nettype wire

[src/tfa_sum_ram.sv]
// Running-sum store: one write port, one read port, registered read data.
// Uses tfa_pkg for the sum width.
`default_nettype none

module tfa_sum_ram #(
    parameter int DEPTH  = 1048576,
    parameter int ADDR_W = 20
) (
    input  wire                       clk,
    input  wire                       wr_en,
    input  wire  [ADDR_W-1:0]         wr_addr,
    input  wire  [tfa_pkg::SUM_W-1:0] wr_data,
    input  wire                       rd_en,
    input  wire  [ADDR_W-1:0]         rd_addr,
    output logic [tfa_pkg::SUM_W-1:0] rd_data
);
    import tfa_pkg::*;

    logic [SUM_W-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[src/tfa_divider.sv]
// Pipelined restoring divider, eight quotient bits per stage, with stall.
// Uses tfa_pkg (div_chunk, div_side_t) and the assertion macro header.
`default_nettype none
`include "temporal_frame_averager_defines.svh"

module tfa_divider (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        in_valid,
    output logic                       in_ready,
    input  wire  [tfa_pkg::SUM_W-1:0]  in_dividend,
    input  tfa_pkg::div_side_t         in_side,
    output logic                       out_valid,
    input  wire                        out_ready,
    output logic [tfa_pkg::DVD_W-1:0]  out_quot,
    output tfa_pkg::div_side_t         out_side
);
    import tfa_pkg::*;

    logic                v_reg    [0:DIV_STAGES];
    logic [DVD_W-1:0]    dvd_reg  [0:DIV_STAGES];
    logic [FRAMES_W-1:0] rem_reg  [0:DIV_STAGES];
    logic [DVD_W-1:0]    quo_reg  [0:DIV_STAGES];
    div_side_t           side_reg [0:DIV_STAGES];

    logic                       en   [0:DIV_STAGES];
    logic [FRAMES_W+CHUNK_W-1:0] step [1:DIV_STAGES];

    always_comb
    begin
        en[DIV_STAGES] = !v_reg[DIV_STAGES] || out_ready;
        for (int s = DIV_STAGES - 1; s >= 0; s--)
        begin
            en[s] = !v_reg[s] || en[s+1];
        end
        for (int s = 1; s <= DIV_STAGES; s++)
        begin
            step[s] = div_chunk(rem_reg[s-1], dvd_reg[s-1][DVD_W-1 -: CHUNK_W],
                                side_reg[s-1].divisor);
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[DIV_STAGES];
    assign out_quot  = quo_reg[DIV_STAGES];
    assign out_side  = side_reg[DIV_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= DIV_STAGES; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int s = 1; s <= DIV_STAGES; s++)
            begin
                if (en[s])
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0] && in_valid)
        begin
            dvd_reg[0]  <= DVD_W'(in_dividend);
            rem_reg[0]  <= '0;
            quo_reg[0]  <= '0;
            side_reg[0] <= in_side;
        end
        for (int s = 1; s <= DIV_STAGES; s++)
        begin
            if (en[s] && v_reg[s-1])
            begin
                dvd_reg[s]  <= dvd_reg[s-1] << CHUNK_W;
                rem_reg[s]  <= step[s][FRAMES_W+CHUNK_W-1:CHUNK_W];
                quo_reg[s]  <= {quo_reg[s-1][DVD_W-CHUNK_W-1:0], step[s][CHUNK_W-1:0]};
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    `TFA_ASSERT_IMP(a_rem_below_divisor, clk, rst_n, v_reg[DIV_STAGES], rem_reg[DIV_STAGES] < side_reg[DIV_STAGES].divisor)

endmodule

`default_nettype wire

[src/temporal_frame_averager.sv]
// Temporal frame averager top level: registers, counters, sum update, output.
// Uses tfa_pkg, tfa_sum_ram, tfa_divider and the assertion macro header.
//
// Averages groups of video frames element by element. Samples stream in one
// item per clock while the output side does not stall; every sample item does
// a read-modify-write of its element's running sum in a single-port-read,
// single-port-write memory (registered read, back-to-back updates of the same
// element are forwarded), so the sustained rate is one item per cycle, set by
// that memory port pair. Results appear during the last frame of each group,
// after the sum read and update stage, the divider (eight quotient bits per
// stage) and the output register. Flush and unused-format items are taken
// without touching the sum store and give no result. The sum store needs no
// clearing pass: the first frame of a group overwrites it.
`default_nettype none
`include "temporal_frame_averager_defines.svh"

module temporal_frame_averager #(
    parameter int MAX_ELEMENTS = 1048576,
    parameter int MAX_FRAMES   = 100
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cfg_we,
    input  wire  [tfa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [tfa_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire                             in_valid,
    output logic                            in_ready,
    input  wire                             command,
    input  wire  [tfa_pkg::SAMPLE_W-1:0]    sample,
    output logic                            out_valid,
    input  wire                             out_ready,
    output logic [tfa_pkg::SAMPLE_W-1:0]    average_sample,
    output logic                            last_of_frame
);
    import tfa_pkg::*;

    localparam int ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int ECNT_W = (ADDR_W + 1 > ELEMS_W) ? ADDR_W + 1 : ELEMS_W;
    localparam int FIDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int NCNT_W = 9;

    localparam logic [ECNT_W-1:0] MAX_E = ECNT_W'(MAX_ELEMENTS);
    localparam logic [NCNT_W-1:0] MAX_N = NCNT_W'(MAX_FRAMES);

    // configuration
    logic [FRAMES_W-1:0] frames_reg;
    logic [FMT_W-1:0]    format_reg;
    logic [ELEMS_W-1:0]  elements_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg   <= FRAMES_RESET;
            format_reg   <= FORMAT_RESET;
            elements_reg <= ELEMENTS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAMES:   frames_reg   <= cfg_data[FRAMES_W-1:0];
                REG_FORMAT:   format_reg   <= cfg_data[FMT_W-1:0];
                REG_ELEMENTS: elements_reg <= cfg_data[ELEMS_W-1:0];
                default:      ;
            endcase
        end
    end

    logic [NCNT_W-1:0] frames_ext;
    logic [NCNT_W-1:0] eff_n;
    logic [ECNT_W-1:0] elems_ext;
    logic [ECNT_W-1:0] eff_e;

    assign frames_ext = NCNT_W'(frames_reg);
    assign elems_ext  = ECNT_W'(elements_reg);
    assign eff_n = (frames_ext == '0) ? NCNT_W'(1) : ((frames_ext > MAX_N) ? MAX_N : frames_ext);
    assign eff_e = (elems_ext == '0) ? ECNT_W'(1) : ((elems_ext > MAX_E) ? MAX_E : elems_ext);

    // position counters
    logic [FIDX_W-1:0] frame_index_reg;
    logic [ADDR_W-1:0] element_position_reg;
    logic [FIDX_W-1:0] frame_index_next;
    logic [ADDR_W-1:0] element_position_next;

    logic last_frame;
    logic last_elem;
    logic accept;
    logic samp_acc;
    logic flush_acc;

    assign last_frame = (NCNT_W'(frame_index_reg) + NCNT_W'(1)) >= eff_n;
    assign last_elem  = (ECNT_W'(element_position_reg) + ECNT_W'(1)) >= eff_e;
    assign accept     = in_valid && in_ready;
    assign flush_acc  = accept && (command == CMD_FLUSH);
    assign samp_acc   = accept && (command == CMD_SAMPLE) && (format_reg != FMT_UNUSED);

    always_comb
    begin
        frame_index_next      = frame_index_reg;
        element_position_next = element_position_reg;
        if (flush_acc)
        begin
            frame_index_next      = '0;
            element_position_next = '0;
        end
        else if (samp_acc)
        begin
            if (last_elem)
            begin
                element_position_next = '0;
                frame_index_next      = last_frame ? '0 : FIDX_W'(frame_index_reg + 1'b1);
            end
            else
            begin
                element_position_next = ADDR_W'(element_position_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_index_reg      <= '0;
            element_position_reg <= '0;
        end
        else
        begin
            frame_index_reg      <= frame_index_next;
            element_position_reg <= element_position_next;
        end
    end

    logic [SAMPLE_W-1:0] in_val;

    always_comb
    begin
        case (format_reg)
            FMT_8BIT: in_val = {8'h00, sample[7:0]};
            FMT_BE16: in_val = swap_bytes(sample);
            default:  in_val = sample;
        endcase
    end

    // sum update stage
    logic                vb_reg;
    logic [ADDR_W-1:0]   b_addr_reg;
    logic [SAMPLE_W-1:0] b_val_reg;
    logic                b_first_reg;
    logic                b_emit_reg;
    div_side_t           b_side_reg;
    logic                fwd_reg;
    logic [SUM_W-1:0]    fwd_data_reg;

    logic [SUM_W-1:0] rd_data;
    logic [SUM_W-1:0] sum_base;
    logic [SUM_W-1:0] b_sum;
    logic             div_in_ready;
    logic             b_free;
    logic             b_write;

    assign sum_base = fwd_reg ? fwd_data_reg : rd_data;
    assign b_sum    = b_first_reg ? SUM_W'(b_val_reg) : SUM_W'(sum_base + SUM_W'(b_val_reg));
    assign b_free   = !vb_reg || !b_emit_reg || div_in_ready;
    assign b_write  = vb_reg && b_free;
    assign in_ready = b_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
        end
        else if (b_free)
        begin
            vb_reg <= samp_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samp_acc)
        begin
            b_addr_reg        <= element_position_reg;
            b_val_reg         <= in_val;
            b_first_reg       <= (frame_index_reg == '0);
            b_emit_reg        <= last_frame;
            b_side_reg.divisor <= eff_n[FRAMES_W-1:0];
            b_side_reg.fmt    <= format_reg;
            b_side_reg.last   <= last_elem;
            fwd_reg           <= b_write && (b_addr_reg == element_position_reg);
            fwd_data_reg      <= b_sum;
        end
    end

    tfa_sum_ram #(
        .DEPTH  (MAX_ELEMENTS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (b_write),
        .wr_addr (b_addr_reg),
        .wr_data (b_sum),
        .rd_en   (samp_acc),
        .rd_addr (element_position_reg),
        .rd_data (rd_data)
    );

    // divide and output
    logic             div_out_valid;
    logic             div_out_ready;
    logic [DVD_W-1:0] div_quot;
    div_side_t        div_side;

    tfa_divider u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (vb_reg && b_emit_reg),
        .in_ready    (div_in_ready),
        .in_dividend (b_sum),
        .in_side     (b_side_reg),
        .out_valid   (div_out_valid),
        .out_ready   (div_out_ready),
        .out_quot    (div_quot),
        .out_side    (div_side)
    );

    logic                out_v_reg;
    logic [SAMPLE_W-1:0] avg_reg;
    logic                last_reg;
    logic [SAMPLE_W-1:0] avg_fmt;

    always_comb
    begin
        case (div_side.fmt)
            FMT_8BIT: avg_fmt = {8'h00, div_quot[7:0]};
            FMT_BE16: avg_fmt = swap_bytes(div_quot[SAMPLE_W-1:0]);
            default:  avg_fmt = div_quot[SAMPLE_W-1:0];
        endcase
    end

    assign div_out_ready = !out_v_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (div_out_ready)
        begin
            out_v_reg <= div_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_out_ready && div_out_valid)
        begin
            avg_reg  <= avg_fmt;
            last_reg <= div_side.last;
        end
    end

    assign out_valid      = out_v_reg;
    assign average_sample = avg_reg;
    assign last_of_frame  = last_reg;

    `TFA_ASSERT_NEXT(a_fwd_same_entry, clk, rst_n, samp_acc && vb_reg && (b_addr_reg == element_position_reg), fwd_reg)
    `TFA_ASSERT_NEXT(a_flush_clears, clk, rst_n, flush_acc, (frame_index_reg == '0) && (element_position_reg == '0))
    `TFA_ASSERT_IMP(a_hold_when_stuck, clk, rst_n, vb_reg && b_emit_reg && !div_in_ready, !in_ready)

endmodule

`default_nettype wire

[dv/tb_temporal_frame_averager.sv]
// Self-checking testbench for temporal_frame_averager: directed and random frame groups.
// Drives random idles on both channels and checks each average against a local predictor.
// Depends on tfa_pkg and the temporal_frame_averager top level.
`default_nettype none

module tb_temporal_frame_averager;

    import tfa_pkg::*;

    localparam int MAX_ELEMENTS  = 1048576;
    localparam int MAX_FRAMES    = 100;
    localparam int IDLE_PCT      = 31;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 200;
    localparam int RANDOM_ITEMS  = 1650;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] avg;
        logic                last;
    } average_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  command;
    logic [SAMPLE_W-1:0]   sample;
    logic                  out_valid;
    logic                  out_ready;
    logic [SAMPLE_W-1:0]   average_sample;
    logic                  last_of_frame;

    // predictor state
    bit [SUM_W-1:0]     sum_mem [int unsigned];
    logic [FRAMES_W-1:0] frame_idx;
    logic [19:0]         elem_pos;
    logic [FRAMES_W-1:0] frames_reg;
    logic [FMT_W-1:0]    format_reg;
    logic [ELEMS_W-1:0]  elements_reg;
    average_t            expected_averages [$];

    int  error_count = 0;
    int  random_items;
    int  cycle_count;
    bit  steady;
    bit  hold_request;
    bit  hold_done;

    temporal_frame_averager #(
        .MAX_ELEMENTS(MAX_ELEMENTS),
        .MAX_FRAMES(MAX_FRAMES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .sample(sample),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .average_sample(average_sample),
        .last_of_frame(last_of_frame)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned eff_frame_count();
        if (frames_reg == 0)
            return 1;
        if (frames_reg > MAX_FRAMES)
            return MAX_FRAMES;
        return 32'(frames_reg);
    endfunction

    function automatic int unsigned eff_frame_length();
        if (elements_reg == 0)
            return 1;
        if (elements_reg > MAX_ELEMENTS)
            return MAX_ELEMENTS;
        return 32'(elements_reg);
    endfunction

    function automatic void predict_average(input logic cmd, input logic [SAMPLE_W-1:0] raw);
        int unsigned n;
        int unsigned e;
        int unsigned pos;
        int unsigned val;
        int unsigned total;
        int unsigned q;
        logic [SAMPLE_W-1:0] avg;
        bit frame_done;
        bit group_done;
        if (cmd == CMD_FLUSH)
        begin
            frame_idx = '0;
            elem_pos  = '0;
            return;
        end
        if (format_reg == FMT_UNUSED)
            return;
        n   = eff_frame_count();
        e   = eff_frame_length();
        pos = 32'(elem_pos);
        case (format_reg)
            FMT_8BIT: val = 32'(raw[7:0]);
            FMT_BE16: val = 32'({raw[7:0], raw[15:8]});
            default:  val = 32'(raw);
        endcase
        if (frame_idx == 0)
            total = val;
        else
            total = (sum_mem[pos] + val) % (1 << SUM_W);
        sum_mem[pos] = total[SUM_W-1:0];
        group_done = (frame_idx + 1 >= n);
        frame_done = (pos + 1 >= e);
        if (group_done)
        begin
            q   = total / n;
            avg = (format_reg == FMT_8BIT) ? {8'h00, q[7:0]} : q[15:0];
            if (format_reg == FMT_BE16)
                avg = {avg[7:0], avg[15:8]};
            expected_averages.push_back('{avg, frame_done});
        end
        if (frame_done)
        begin
            elem_pos  = '0;
            frame_idx = group_done ? '0 : frame_idx + 1'b1;
        end
        else
        begin
            elem_pos = 20'(pos + 1);
        end
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 16)
            return '1;
        return SAMPLE_W'($urandom);
    endfunction

    task automatic send_item(input logic cmd, input logic [SAMPLE_W-1:0] smp);
        int gap;
        if (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            gap = $urandom_range(1, 2);
            @(negedge clk);
            in_valid = 1'b0;
            command  = 1'($urandom);
            sample   = SAMPLE_W'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        command  = cmd;
        sample   = smp;
        do @(posedge clk); while (!in_ready);
        predict_average(cmd, smp);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_averages.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        logic [CFG_DATA_W-1:0] word;
        word = CFG_DATA_W'($urandom);
        case (idx)
            REG_FRAMES:
            begin
                word[FRAMES_W-1:0] = FRAMES_W'(value);
                frames_reg = FRAMES_W'(value);
            end
            REG_FORMAT:
            begin
                word[FMT_W-1:0] = FMT_W'(value);
                format_reg = FMT_W'(value);
            end
            default:
            begin
                word = ELEMS_W'(value);
                elements_reg = ELEMS_W'(value);
            end
        endcase
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = word;
        @(negedge clk);
        cfg_we    = 1'b0;
        cfg_data  = CFG_DATA_W'($urandom);
    endtask

    task automatic test_reset_defaults();
        send_item(CMD_SAMPLE, 16'h00FF);
        send_item(CMD_SAMPLE, 16'hFF00);
        send_item(CMD_FLUSH, 16'hFFFF);
        wait_idle();
    endtask

    task automatic test_sample_formats();
        write_reg(REG_FRAMES, 0);
        write_reg(REG_ELEMENTS, 0);
        write_reg(REG_FORMAT, 32'(FMT_8BIT));
        send_item(CMD_SAMPLE, 16'hFFFF);
        send_item(CMD_SAMPLE, 16'h0000);
        send_item(CMD_SAMPLE, 16'hA55A);
        wait_idle();
        write_reg(REG_FORMAT, 32'(FMT_LE16));
        send_item(CMD_SAMPLE, 16'hFFFF);
        send_item(CMD_SAMPLE, 16'h8001);
        wait_idle();
        write_reg(REG_FORMAT, 32'(FMT_BE16));
        send_item(CMD_SAMPLE, 16'h1234);
        send_item(CMD_SAMPLE, 16'h00FF);
        wait_idle();
        write_reg(REG_FORMAT, 32'(FMT_UNUSED));
        send_item(CMD_SAMPLE, 16'h5A5A);
        send_item(CMD_SAMPLE, 16'hFFFF);
        wait_idle();
    endtask

    task automatic test_count_limits();
        write_reg(REG_FRAMES, 1);
        write_reg(REG_FORMAT, 32'(FMT_LE16));
        write_reg(REG_ELEMENTS, (1 << ELEMS_W) - 1);
        send_item(CMD_SAMPLE, 16'hFFFF);
        send_item(CMD_SAMPLE, 16'h0001);
        send_item(CMD_SAMPLE, 16'h7FFE);
        wait_idle();
        write_reg(REG_ELEMENTS, MAX_ELEMENTS);
        send_item(CMD_SAMPLE, 16'hC3C3);
        send_item(CMD_FLUSH, 16'h0000);
        wait_idle();
    endtask

    // frame length shrinks below the current position: that item closes the frame
    task automatic test_midframe_change();
        write_reg(REG_FRAMES, 2);
        write_reg(REG_ELEMENTS, 4);
        write_reg(REG_FORMAT, 32'(FMT_BE16));
        send_item(CMD_SAMPLE, 16'hFF01);
        send_item(CMD_SAMPLE, 16'h0080);
        send_item(CMD_SAMPLE, 16'hFFFF);
        wait_idle();
        write_reg(REG_ELEMENTS, 2);
        send_item(CMD_SAMPLE, 16'h1111);
        send_item(CMD_SAMPLE, 16'hFF03);
        send_item(CMD_SAMPLE, 16'h0180);
        wait_idle();
    endtask

    task automatic test_backpressure();
        send_item(CMD_FLUSH, 16'h0000);
        wait_idle();
        write_reg(REG_FRAMES, 1);
        write_reg(REG_FORMAT, 32'(FMT_LE16));
        write_reg(REG_ELEMENTS, 8);
        steady       = 1'b1;
        hold_request = 1'b1;
        repeat (60) send_item(CMD_SAMPLE, random_sample());
        steady = 1'b0;
        wait_idle();
    endtask

    task automatic test_steady_stream();
        write_reg(REG_FRAMES, 2);
        write_reg(REG_ELEMENTS, 5);
        steady = 1'b1;
        repeat (150) send_item(CMD_SAMPLE, random_sample());
        steady = 1'b0;
        random_items += 150;
        wait_idle();
    endtask

    task automatic retune_mid_group();
        int unsigned e;
        wait_idle();
        case ($urandom_range(0, 2))
            0: write_reg(REG_FRAMES, $urandom_range(1, 6));
            1: write_reg(REG_FORMAT, $urandom_range(FMT_8BIT, FMT_BE16));
            default:
            begin
                e = eff_frame_length();
                write_reg(REG_ELEMENTS, $urandom_range(1, (e > 16) ? 16 : e));
            end
        endcase
    endtask

    task automatic test_random_groups();
        int unsigned frames_val;
        int unsigned fmt_val;
        int unsigned elems_val;
        int unsigned new_len;
        int unsigned span;
        int unsigned n_items;
        int unsigned r;
        while (random_items < RANDOM_ITEMS)
        begin
            wait_idle();
            case ($urandom_range(0, 9))
                0:       frames_val = 0;
                1:       frames_val = MAX_FRAMES;
                2:       frames_val = (1 << FRAMES_W) - 1;
                3:       frames_val = 1;
                default: frames_val = $urandom_range(2, 6);
            endcase
            fmt_val = ($urandom_range(0, 19) == 0) ? FMT_UNUSED
                                                   : $urandom_range(FMT_8BIT, FMT_BE16);
            if (frames_val >= MAX_FRAMES / 2)
            begin
                elems_val = $urandom_range(0, 2);
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0:       elems_val = 0;
                    1:       elems_val = MAX_ELEMENTS;
                    2:       elems_val = (1 << ELEMS_W) - 1;
                    default: elems_val = $urandom_range(1, 16);
                endcase
            end
            new_len = (elems_val == 0) ? 1 : ((elems_val > MAX_ELEMENTS) ? MAX_ELEMENTS
                                                                         : elems_val);
            // longer frames would read sums never written in this group
            if (new_len > eff_frame_length() && frame_idx != 0)
            begin
                send_item(CMD_FLUSH, random_sample());
                wait_idle();
            end
            write_reg(REG_FRAMES, frames_val);
            write_reg(REG_ELEMENTS, elems_val);
            write_reg(REG_FORMAT, fmt_val);
            span = eff_frame_count() * eff_frame_length();
            if (fmt_val == FMT_UNUSED)
                n_items = $urandom_range(3, 8);
            else if (eff_frame_length() > 64)
                n_items = $urandom_range(10, 40);
            else
                n_items = span * $urandom_range(1, 2) + $urandom_range(0, 3);
            if (n_items > 400)
                n_items = 400;
            for (int i = 0; i < n_items; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    send_item(CMD_FLUSH, random_sample());
                else if (r < 5)
                    retune_mid_group();
                else
                    send_item(CMD_SAMPLE, random_sample());
                if (format_reg != FMT_UNUSED)
                    random_items++;
            end
        end
    endtask

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                out_ready = 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++)
                    @(negedge clk);
                hold_done = 1'b1;
            end
            out_ready = steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin : check_averages
        average_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_averages.size() == 0)
            begin
                $display("%0t: unexpected item: expected none, got average_sample %h last %b",
                         $time, average_sample, last_of_frame);
                error_count++;
            end
            else
            begin
                want = expected_averages.pop_front();
                if (want.avg !== average_sample)
                begin
                    $display("%0t: average_sample expected %h got %h",
                             $time, want.avg, average_sample);
                    error_count++;
                end
                if (want.last !== last_of_frame)
                begin
                    $display("%0t: last_of_frame expected %b got %b",
                             $time, want.last, last_of_frame);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_FRAMES;
        cfg_data     = '0;
        in_valid     = 1'b0;
        command      = CMD_SAMPLE;
        sample       = '0;
        steady       = 1'b0;
        hold_request = 1'b0;
        random_items = 0;
        frame_idx    = '0;
        elem_pos     = '0;
        frames_reg   = FRAMES_RESET;
        format_reg   = FORMAT_RESET;
        elements_reg = ELEMENTS_RESET;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_sample_formats();
        test_count_limits();
        test_midframe_change();
        test_backpressure();
        test_steady_stream();
        test_random_groups();
        wait_idle();

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
